// ----- sv/qsu_pkg.sv -----
package qsu_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned CountW = 2;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned OctMaxDigits = 3;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [PhaseW-1:0] PH_LEAD = 3'd0;
  localparam logic [PhaseW-1:0] PH_IN   = 3'd1;
  localparam logic [PhaseW-1:0] PH_ESC  = 3'd2;
  localparam logic [PhaseW-1:0] PH_HEX  = 3'd3;
  localparam logic [PhaseW-1:0] PH_OCT  = 3'd4;
  localparam logic [PhaseW-1:0] PH_TAIL = 3'd5;
  localparam logic [PhaseW-1:0] PH_ERR  = 3'd6;

  localparam logic [KindW-1:0] KIND_BYTE = 2'd0;
  localparam logic [KindW-1:0] KIND_DONE = 2'd1;
  localparam logic [KindW-1:0] KIND_ERR  = 2'd2;

  localparam logic [ByteW-1:0] CH_NUL    = 8'h00;
  localparam logic [ByteW-1:0] CH_QUOTE  = 8'h22;
  localparam logic [ByteW-1:0] CH_BSLASH = 8'h5c;
  localparam logic [ByteW-1:0] CH_HEX    = 8'h78;

  // One queue entry holds every result that a single input byte causes.
  typedef struct packed {
    logic [ByteW-1:0] byte0;
    logic [KindW-1:0] kind0;
    logic [ByteW-1:0] byte1;
    logic [KindW-1:0] kind1;
    logic             two;
  } qsu_entry_t;

  function automatic logic is_ws(input logic [ByteW-1:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b) ||
           (c == 8'h0c) || (c == 8'h0d);
  endfunction

  function automatic logic is_hex(input logic [ByteW-1:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [ByteW-1:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic is_oct(input logic [ByteW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  // Named C escapes; any other byte stands for itself.
  function automatic logic [ByteW-1:0] esc_named(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] v;
    case (c)
      8'h61:   v = 8'd7;
      8'h62:   v = 8'd8;
      8'h66:   v = 8'd12;
      8'h6e:   v = 8'd10;
      8'h72:   v = 8'd13;
      8'h74:   v = 8'd9;
      8'h76:   v = 8'd11;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/qsu_if.sv -----
interface qsu_in_if import qsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface qsu_out_if import qsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic [KindW-1:0] result_kind;
  logic             run_last;

  modport source (output valid, output out_byte, output result_kind, output run_last,
                  input ready);
  modport sink (input valid, input out_byte, input result_kind, input run_last,
                output ready);
endinterface

// ----- sv/qsu_front.sv -----
module qsu_front import qsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             ready_o,
  input  logic             full_i,
  output logic             push_o,
  output qsu_entry_t       entry_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  val_q, val_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  logic              acc;
  logic              has0, has1;
  logic [ByteW-1:0]  b0, b1;
  logic [KindW-1:0]  k0, k1;

  // Handling of a byte as plain string content, shared by the string phase
  // and by the flush at the end of a numeric escape.
  logic              s_has;
  logic [ByteW-1:0]  s_byte;
  logic [KindW-1:0]  s_kind;
  logic [PhaseW-1:0] s_phase;
  logic              s_end;

  logic [ByteW-1:0]  oct_next;
  logic [CountW-1:0] cnt_inc;

  assign ready_o = !full_i;
  assign acc     = valid_i && ready_o;
  assign oct_next = {val_q[4:0], in_byte_i[2:0]};
  assign cnt_inc  = cnt_q + 2'd1;

  always_comb begin
    s_has   = 1'b0;
    s_byte  = in_byte_i;
    s_kind  = KIND_BYTE;
    s_phase = PH_IN;
    s_end   = 1'b0;
    if (in_byte_i == CH_NUL) begin
      s_has   = 1'b1;
      s_byte  = CH_NUL;
      s_kind  = KIND_ERR;
      s_phase = PH_LEAD;
      s_end   = 1'b1;
    end else if (in_byte_i == CH_QUOTE) begin
      s_phase = PH_TAIL;
    end else if (in_byte_i == CH_BSLASH) begin
      s_phase = PH_ESC;
    end else begin
      s_has = 1'b1;
    end
  end

  always_comb begin
    phase_d = phase_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    has0    = 1'b0;
    has1    = 1'b0;
    b0      = CH_NUL;
    k0      = KIND_BYTE;
    b1      = CH_NUL;
    k1      = KIND_BYTE;
    case (phase_q)
      PH_LEAD: begin
        if (in_byte_i == CH_NUL) begin
          has0 = 1'b1;
          k0   = KIND_ERR;
        end else if (in_byte_i == CH_QUOTE) begin
          phase_d = PH_IN;
        end else if (!is_ws(in_byte_i)) begin
          phase_d = PH_ERR;
        end
      end
      PH_IN: begin
        has0    = s_has;
        b0      = s_byte;
        k0      = s_kind;
        phase_d = s_phase;
        if (s_end) begin
          val_d = '0;
          cnt_d = '0;
        end
      end
      PH_ESC: begin
        phase_d = PH_IN;
        if (in_byte_i == CH_NUL) begin
          has0    = 1'b1;
          k0      = KIND_ERR;
          phase_d = PH_LEAD;
          val_d   = '0;
          cnt_d   = '0;
        end else if (in_byte_i == CH_HEX) begin
          phase_d = PH_HEX;
          val_d   = '0;
          cnt_d   = '0;
        end else if (is_oct(in_byte_i)) begin
          phase_d = PH_OCT;
          val_d   = {5'd0, in_byte_i[2:0]};
          cnt_d   = 2'd1;
        end else begin
          has0 = 1'b1;
          b0   = esc_named(in_byte_i);
        end
      end
      PH_HEX: begin
        if (is_hex(in_byte_i)) begin
          val_d = {val_q[3:0], hex_val(in_byte_i)};
          cnt_d = 2'd1;
        end else if (cnt_q == '0) begin
          if (in_byte_i == CH_NUL) begin
            has0    = 1'b1;
            k0      = KIND_ERR;
            phase_d = PH_LEAD;
          end else begin
            phase_d = PH_ERR;
          end
        end else begin
          // Flush the value, then treat the terminating byte as content.
          has0    = 1'b1;
          b0      = val_q;
          has1    = s_has;
          b1      = s_byte;
          k1      = s_kind;
          phase_d = s_phase;
          val_d   = '0;
          cnt_d   = '0;
        end
      end
      PH_OCT: begin
        if (is_oct(in_byte_i)) begin
          if (cnt_inc == CountW'(OctMaxDigits)) begin
            has0    = 1'b1;
            b0      = oct_next;
            phase_d = PH_IN;
            val_d   = '0;
            cnt_d   = '0;
          end else begin
            val_d = oct_next;
            cnt_d = cnt_inc;
          end
        end else begin
          has0    = 1'b1;
          b0      = val_q;
          has1    = s_has;
          b1      = s_byte;
          k1      = s_kind;
          phase_d = s_phase;
          val_d   = '0;
          cnt_d   = '0;
        end
      end
      PH_TAIL: begin
        if (in_byte_i == CH_NUL) begin
          has0    = 1'b1;
          k0      = KIND_DONE;
          phase_d = PH_LEAD;
          val_d   = '0;
          cnt_d   = '0;
        end else if (!is_ws(in_byte_i)) begin
          phase_d = PH_ERR;
        end
      end
      default: begin
        if (in_byte_i == CH_NUL) begin
          has0    = 1'b1;
          k0      = KIND_ERR;
          phase_d = PH_LEAD;
          val_d   = '0;
          cnt_d   = '0;
        end else begin
          phase_d = PH_ERR;
        end
      end
    endcase
  end

  assign push_o        = acc && has0;
  assign entry_o.byte0 = b0;
  assign entry_o.kind0 = k0;
  assign entry_o.byte1 = b1;
  assign entry_o.kind1 = k1;
  assign entry_o.two   = has1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      val_q   <= '0;
      cnt_q   <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      val_q   <= val_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- sv/qsu_fifo.sv -----
module qsu_fifo import qsu_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  qsu_entry_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output qsu_entry_t data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  qsu_entry_t        mem_q [Depth];
  logic [AddrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/qsu_back.sv -----
module qsu_back import qsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  qsu_entry_t       q_data_i,
  output logic             q_pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic [KindW-1:0] result_kind_o,
  output logic             run_last_o
);

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic [KindW-1:0] out_kind_q;
  logic             out_last_q;
  logic             pend_q;
  logic [ByteW-1:0] pend_byte_q;
  logic [KindW-1:0] pend_kind_q;
  logic             load;

  assign load    = !out_valid_q || ready_i;
  assign q_pop_o = load && !pend_q && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= q_valid_i;
        pend_q      <= q_valid_i && q_data_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        out_byte_q <= pend_byte_q;
        out_kind_q <= pend_kind_q;
        out_last_q <= 1'b1;
      end else begin
        out_byte_q  <= q_data_i.byte0;
        out_kind_q  <= q_data_i.kind0;
        out_last_q  <= !q_data_i.two;
        pend_byte_q <= q_data_i.byte1;
        pend_kind_q <= q_data_i.kind1;
      end
    end
  end

  assign valid_o       = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign result_kind_o = out_kind_q;
  assign run_last_o    = out_last_q;

endmodule

// ----- sv/quoted_string_unescaper.sv -----
// Quoted string unescaper.
//
// Channel in_i carries one byte of a text line per request; a zero byte ends
// the line. Channel out_o carries results: a decoded string byte, a done
// status or a syntax-error status, with run_last marking the last result of
// an input byte. Both channels use valid/ready and move a request on a clock
// edge where both are high.
//
// A byte is accepted every cycle while the result queue has room. The front
// end decodes the byte in the cycle it is accepted and writes its results
// into the queue as one entry; the back end drains that queue into an output
// register, one result per cycle while out_o.ready is high. Results pass
// through the queue and then the output register before they reach out_o.
// A byte that ends a numeric escape can yield two results, which leave the
// output one after the other; the queue of QueueDepth entries absorbs that,
// so input runs at one byte per cycle unless such bytes outpace the output.
//
// Reset returns the decoder to the leading-whitespace phase and empties the
// queue and the output register. When the receiver holds ready low, the
// output holds its result, the queue fills, and in_i.ready drops when full.
module quoted_string_unescaper import qsu_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  qsu_in_if.sink    in_i,
  qsu_out_if.source out_o
);

  logic       full;
  logic       push;
  logic       pop;
  logic       q_valid;
  qsu_entry_t push_entry;
  qsu_entry_t head_entry;

  // Front end: parses the line and turns each byte that has results into a queue entry.
  qsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .in_byte_i (in_i.in_byte),
    .ready_o   (in_i.ready),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  // Queue between the parser and the result serializer.
  qsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_entry)
  );

  // Back end: emits the one or two results of each entry.
  qsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (head_entry),
    .q_pop_o       (pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .result_kind_o (out_o.result_kind),
    .run_last_o    (out_o.run_last)
  );

endmodule

// ----- sv/qsu_checker.sv -----
module qsu_checker import qsu_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_i,
  input logic [KindW-1:0] result_kind_i,
  input logic             run_last_i
);

  // A status result always closes the results of its input byte.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i != KIND_BYTE) |-> run_last_i)
    else $error("status result without run_last");

  // Status results carry a zero byte.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i != KIND_BYTE) |-> (out_byte_i == '0))
    else $error("status result with nonzero byte");

  // Only byte, done and error kinds exist.
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (result_kind_i == KIND_BYTE) || (result_kind_i == KIND_DONE) ||
                    (result_kind_i == KIND_ERR))
    else $error("unknown result kind");

  // A result that is not last is followed directly by its partner.
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !run_last_i |=> out_valid_i)
    else $error("second result of a byte not presented next cycle");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
                                    $stable(result_kind_i) && $stable(run_last_i))
    else $error("stalled result changed");

endmodule

bind quoted_string_unescaper qsu_checker u_qsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .result_kind_i (out_o.result_kind),
  .run_last_i    (out_o.run_last)
);

// ----- verif/unescape_checker.sv -----
module unescape_checker import qsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  qsu_in_if    in_mon_i,
  qsu_out_if   out_mon_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [KindW-1:0] kind;
    logic             last;
  } decoded_t;

  // Decoder state, kept in step with the block.
  logic [PhaseW-1:0] phase_r;
  logic [ByteW-1:0]  esc_acc;
  logic [CountW-1:0] esc_digits;

  decoded_t decoded_q[$];  // results still owed by the block, oldest first
  decoded_t step_q[$];     // results of the byte being decoded
  decoded_t head;
  int       fails;

  assign fail_count_o = fails;

  function automatic logic is_blank(input logic [ByteW-1:0] c);
    return c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  endfunction

  function automatic void add_result(input logic [ByteW-1:0] data, input logic [KindW-1:0] kind);
    decoded_t r;
    r.data = data;
    r.kind = kind;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  // End of line: report the status and start over in the leading phase.
  function automatic void close_line(input logic [KindW-1:0] kind);
    add_result('0, kind);
    phase_r    = PH_LEAD;
    esc_acc    = '0;
    esc_digits = '0;
  endfunction

  function automatic void string_char(input logic [ByteW-1:0] c);
    if (c == CH_NUL) begin
      close_line(KIND_ERR);
    end else if (c == CH_QUOTE) begin
      phase_r = PH_TAIL;
    end else if (c == CH_BSLASH) begin
      phase_r = PH_ESC;
    end else begin
      add_result(c, KIND_BYTE);
      phase_r = PH_IN;
    end
  endfunction

  function automatic void decode_byte(input logic [ByteW-1:0] c);
    logic             is_digit;
    logic [3:0]       nib;
    logic [ByteW-1:0] v;
    decoded_t         r;
    step_q.delete();
    case (phase_r)
      PH_LEAD: begin
        if (c == CH_NUL) begin
          close_line(KIND_ERR);
        end else if (c == CH_QUOTE) begin
          phase_r = PH_IN;
        end else if (!is_blank(c)) begin
          phase_r = PH_ERR;
        end
      end
      PH_IN: begin
        string_char(c);
      end
      PH_ESC: begin
        phase_r = PH_IN;
        if (c == CH_NUL) begin
          close_line(KIND_ERR);
        end else if (c == CH_HEX) begin
          phase_r    = PH_HEX;
          esc_acc    = '0;
          esc_digits = '0;
        end else if (c >= "0" && c <= "7") begin
          phase_r    = PH_OCT;
          esc_acc    = {5'd0, c[2:0]};
          esc_digits = 2'd1;
        end else begin
          case (c)
            "a":     v = 8'd7;
            "b":     v = 8'd8;
            "f":     v = 8'd12;
            "n":     v = 8'd10;
            "r":     v = 8'd13;
            "t":     v = 8'd9;
            "v":     v = 8'd11;
            default: v = c;
          endcase
          add_result(v, KIND_BYTE);
        end
      end
      PH_HEX: begin
        is_digit = 1'b1;
        nib      = '0;
        if (c >= "0" && c <= "9") begin
          nib = c[3:0];
        end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
          nib = c[3:0] + 4'd9;
        end else begin
          is_digit = 1'b0;
        end
        if (is_digit) begin
          // Only the low eight bits of a long hex value survive.
          esc_acc    = {esc_acc[3:0], nib};
          esc_digits = 2'd1;
        end else if (esc_digits == 0) begin
          if (c == CH_NUL) begin
            close_line(KIND_ERR);
          end else begin
            phase_r = PH_ERR;
          end
        end else begin
          add_result(esc_acc, KIND_BYTE);
          esc_acc    = '0;
          esc_digits = '0;
          string_char(c);
        end
      end
      PH_OCT: begin
        if (c >= "0" && c <= "7" && esc_digits < OctMaxDigits) begin
          esc_acc    = (esc_acc << 3) + {5'd0, c[2:0]};
          esc_digits = esc_digits + 2'd1;
          if (esc_digits >= OctMaxDigits) begin
            add_result(esc_acc, KIND_BYTE);
            esc_acc    = '0;
            esc_digits = '0;
            phase_r    = PH_IN;
          end
        end else begin
          add_result(esc_acc, KIND_BYTE);
          esc_acc    = '0;
          esc_digits = '0;
          string_char(c);
        end
      end
      PH_TAIL: begin
        if (c == CH_NUL) begin
          close_line(KIND_DONE);
        end else if (!is_blank(c)) begin
          phase_r = PH_ERR;
        end
      end
      default: begin
        if (c == CH_NUL) begin
          close_line(KIND_ERR);
        end else begin
          phase_r = PH_ERR;
        end
      end
    endcase
    if (step_q.size() > 0) begin
      step_q[step_q.size()-1].last = 1'b1;
    end
    foreach (step_q[i]) begin
      r = step_q[i];
      decoded_q.push_back(r);
    end
  endfunction

  function automatic void check_field(input string field, input logic [ByteW-1:0] want,
                                      input logic [ByteW-1:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_r    = PH_LEAD;
      esc_acc    = '0;
      esc_digits = '0;
      decoded_q.delete();
      fails      = 0;
      pending_o <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        decode_byte(in_mon_i.in_byte);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (decoded_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual byte 0x%02h kind %0d last %0b",
                   $time, out_mon_i.out_byte, out_mon_i.result_kind, out_mon_i.run_last);
        end else begin
          head = decoded_q.pop_front();
          check_field("out_byte", head.data, out_mon_i.out_byte);
          check_field("result_kind", {6'd0, head.kind}, {6'd0, out_mon_i.result_kind});
          check_field("run_last", {7'd0, head.last}, {7'd0, out_mon_i.run_last});
        end
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
module testbench import qsu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Longest run of cycles without any request on either channel that a
  // healthy run can show; the long receiver hold-off is well below it.
  localparam int QuietLimit = 2000;
  // Cycles to keep watching after the last expected result, so that stray
  // extra results from the block still get caught.
  localparam int DrainCycles = 20;
  // Length of the receiver hold-off that backs the block up to its input.
  localparam int HoldCycles = 80;
  // Input bytes per idling phase of the random part.
  localparam int BytesPerPhase = 205;

  logic clk_i;
  logic rst_ni;

  qsu_in_if  in_w ();
  qsu_out_if out_w ();

  int         fail_count;
  int         pending;
  int         sent;
  int         idle_pct;   // chance in percent that the sender skips a cycle
  int         stall_pct;  // chance in percent that the receiver drops ready
  bit         hold_req;   // asks the receiver process for one long hold-off
  logic [7:0] line_q[$];  // bytes of the line being built, NUL included

  quoted_string_unescaper u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  unescape_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_w),
    .out_mon_i    (out_w),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A random whitespace byte, from the six that the decoder skips.
  function automatic logic [7:0] blank_char();
    logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    return blanks[$urandom_range(0, 5)];
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_q.push_back(s[i]);
    end
  endfunction

  // Appends one piece of string body: a plain byte, a named escape, an
  // arbitrary escaped byte, a hex escape or an octal escape.
  function automatic void push_token();
    logic [7:0] named [11] = '{"a", "b", "f", "n", "r", "t", "v", "\\", "\"", "'", "?"};
    string      hex_chars;
    logic [7:0] b;
    hex_chars = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 9))
      4: begin
        line_q.push_back(CH_BSLASH);
        line_q.push_back(named[$urandom_range(0, 10)]);
      end
      5: begin
        // Any nonzero byte after a backslash; octal digits and the hex mark start
        // numeric escapes, everything else stands for itself.
        line_q.push_back(CH_BSLASH);
        line_q.push_back(8'($urandom_range(1, 255)));
      end
      6, 7: begin
        line_q.push_back(CH_BSLASH);
        line_q.push_back(CH_HEX);
        repeat ($urandom_range(1, 5)) line_q.push_back(hex_chars[$urandom_range(0, 21)]);
      end
      8, 9: begin
        line_q.push_back(CH_BSLASH);
        repeat ($urandom_range(1, 3)) line_q.push_back(8'("0" + $urandom_range(0, 7)));
      end
      default: begin
        // Plain bytes over the whole range, high bit set included.
        do begin
          b = 8'($urandom_range(1, 255));
        end while (b == CH_QUOTE || b == CH_BSLASH);
        line_q.push_back(b);
      end
    endcase
  endfunction

  // Most lines are well formed, so that the escape phases see real traffic.
  // About one in five is broken on purpose: pure noise, a byte overwritten,
  // the line cut short, or a stray byte slipped in somewhere.
  function automatic void build_line();
    int pos;
    line_q.delete();
    repeat ($urandom_range(0, 2)) line_q.push_back(blank_char());
    line_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 8)) push_token();
    line_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 2)) line_q.push_back(blank_char());
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, line_q.size() - 1);
      case ($urandom_range(0, 3))
        0: begin
          line_q.delete();
          repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(1, 255)));
        end
        1: line_q[pos] = 8'($urandom);
        2: begin
          while (line_q.size() > pos) void'(line_q.pop_back());
        end
        default: line_q.insert(pos, 8'($urandom_range(1, 255)));
      endcase
    end
    line_q.push_back(CH_NUL);
  endfunction

  // Offers one byte after a random number of idle cycles and holds it until
  // the block takes the request. Idle cycles carry junk data with valid low.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_w.valid   <= 1'b0;
      in_w.in_byte <= 8'($urandom);
      @(posedge clk_i);
    end
    in_w.valid   <= 1'b1;
    in_w.in_byte <= b;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_q[i]) begin
      send_byte(line_q[i]);
    end
    sent += line_q.size();
  endtask

  // Receiver: drops ready at random by stall_pct, and on request holds it
  // low for a long stretch so that the result queue fills and the block
  // has to push back on its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_w.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_w.ready <= 1'b0;
      end else begin
        out_w.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: a long stretch with no request on either side means the
  // block has hung, or owes results it will never deliver.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("quoted_string_unescaper test failed");
    $finish;
  end

  initial begin
    int phase_start;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    sent         = 0;
    rst_ni       <= 1'b0;
    in_w.valid   <= 1'b0;
    in_w.in_byte <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines, no idling. A line with no opening quote; a line that
    // ends right after a backslash; a hex escape flushed by the end of the
    // line, which gives a byte and then a syntax error; a hex mark with no
    // digits, followed by a quote that must be ignored; a hex mark cut off
    // by the end of the line.
    line_q.delete();
    push_text("a");
    line_q.push_back(CH_NUL);
    push_text("\"\\");
    line_q.push_back(CH_NUL);
    push_text("\"\\x4");
    line_q.push_back(CH_NUL);
    push_text("\"\\xg\"");
    line_q.push_back(CH_NUL);
    push_text("\"\\x");
    line_q.push_back(CH_NUL);
    send_line();
    // A well-formed line: leading blank, a hex escape ended by a backslash
    // (one result for that byte), a full three-digit octal escape, a short
    // octal escape flushed by a plain byte (two results for one byte), a raw
    // 0xFF, a hex escape giving 0xFF flushed by the closing quote, then
    // trailing blank and done. After that, a short octal escape closed by the
    // quote and trailing garbage that turns the line into a syntax error.
    line_q.delete();
    push_text(" \"\\x41\\101\\7q");
    line_q.push_back(8'hff);
    push_text("\\xff\"\t");
    line_q.push_back(CH_NUL);
    push_text("\"\\12\"z");
    line_q.push_back(CH_NUL);
    send_line();

    // Random lines in four idling phases: none, sender idle, receiver
    // stalling, and both. The first phase opens with the long hold-off
    // while the sender keeps offering requests back to back.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_req  = 1'b1;
        end
        1: begin
          idle_pct  = 58;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 58;
        end
        default: begin
          idle_pct  = 34;
          stall_pct = 34;
        end
      endcase
      phase_start = sent;
      while (sent - phase_start < BytesPerPhase) begin
        build_line();
        send_line();
      end
    end

    // Let the block drain: the checker's count of owed results is registered,
    // so look only from the next edge on.
    in_w.valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("quoted_string_unescaper test passed");
    end else begin
      $display("quoted_string_unescaper test failed");
    end
    $finish;
  end

endmodule
